// File: hw/rtl/ouct_pkg.sv
// Shared types and codes for the ordered unique coordinate table.
// No dependencies; used by ouct_cell and ordered_unique_coordinate_table_core.
package ouct_pkg;

  parameter int unsigned MAX_ENTRIES = 32;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_FIND   = 3'd2,
    CMD_READ   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] letter;
    logic [7:0] number;
    logic [7:0] symbol;
  } entry_t;

  // Command token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic       active;
    logic [2:0] cmd;
    entry_t     key;
    logic [7:0] index;
    logic       hit;    // match (or read position) seen upstream
    logic       added;  // add has written its entry
    entry_t     data;   // entry handed back in the result
  } token_t;

  typedef struct packed {
    status_e    status;
    entry_t     data;
    logic [5:0] count;
    logic       empty;
  } result_t;

endpackage

// File: hw/rtl/ouct_cell.sv
// One table slot: holds one entry and acts on the command token passing by.
// Depends on ouct_pkg.
module ouct_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CntW-1:0]     count_i,
  input  ouct_pkg::token_t    tok_i,
  output ouct_pkg::token_t    tok_o,
  input  ouct_pkg::entry_t    next_entry_i,
  output ouct_pkg::entry_t    entry_o
);

  ouct_pkg::entry_t entry_q, entry_d;
  ouct_pkg::token_t tok_q, tok_d;
  logic             active_q;
  logic             occ;

  assign occ = count_i > CntW'(Idx);

  always_comb begin
    tok_d   = tok_i;
    entry_d = entry_q;
    if (tok_i.active) begin
      unique case (tok_i.cmd)
        ouct_pkg::CMD_ADD: begin
          if (occ && !tok_i.hit && entry_q == tok_i.key) begin
            tok_d.hit = 1'b1;
          end else if (!tok_i.hit && count_i == CntW'(Idx)) begin
            entry_d     = tok_i.key;
            tok_d.added = 1'b1;
          end
        end
        ouct_pkg::CMD_REMOVE: begin
          // close the gap: every slot from the match on takes its successor
          if (occ && !tok_i.hit && entry_q == tok_i.key) begin
            tok_d.hit  = 1'b1;
            tok_d.data = entry_q;
            entry_d    = next_entry_i;
          end else if (tok_i.hit) begin
            entry_d = next_entry_i;
          end
        end
        ouct_pkg::CMD_FIND: begin
          if (occ && !tok_i.hit && entry_q.letter == tok_i.key.letter &&
              entry_q.number == tok_i.key.number) begin
            tok_d.hit  = 1'b1;
            tok_d.data = entry_q;
          end
        end
        ouct_pkg::CMD_READ: begin
          if (occ && tok_i.index == 8'(Idx)) begin
            tok_d.hit  = 1'b1;
            tok_d.data = entry_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= tok_d.active;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q   <= tok_d;
    entry_q <= entry_d;
  end

  always_comb begin
    tok_o        = tok_q;
    tok_o.active = active_q;
  end

  assign entry_o = entry_q;

endmodule

// File: hw/rtl/ordered_unique_coordinate_table_core.sv
// Top level of the ordered unique coordinate table: cell chain, entry count
// and result buffering. Depends on ouct_pkg and ouct_cell.
//
// The table keeps up to MaxEntries unique (letter, number, symbol) entries
// in insertion order, one entry per cell of a chain. Each accepted command
// beat becomes a token that walks the chain one cell per clock: cells
// compare their entry against the key, report a hit, write a new entry at
// the first free slot, or on removal take their successor's entry so that
// the table closes up in order. A command's result is ready once its
// token has passed every cell of the chain, and a new command is taken
// on the cycle after the token has left the chain, so only one command
// is ever in the chain at a time.
// A finished result waits in an output register with one extra holding
// slot behind it, so the next command can run while the result is unread;
// besides the chain walk, input is held off only while both slots are full.
// Slots at or above the entry count are never read, so the entry storage
// needs no reset.
module ordered_unique_coordinate_table_core #(
  parameter int unsigned MaxEntries = ouct_pkg::MAX_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] key_letter, [15:8] key_number, [23:16] key_symbol, [31:24] read_index
  input  logic [31:0] s_axis_tdata_i,
  // [2:0] cmd
  input  logic [2:0]  s_axis_tuser_i,
  // result channel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] status, [9:2] found_letter, [17:10] found_number,
  // [25:18] found_symbol, [31:26] entry_count, [32] table_empty, [39:33] zero
  output logic [39:0] m_axis_tdata_o
);

  localparam int unsigned CntW = $clog2(MaxEntries + 1);

  ouct_pkg::token_t  tok [MaxEntries+1];
  ouct_pkg::entry_t  ent [MaxEntries];
  ouct_pkg::token_t  head;
  ouct_pkg::token_t  tail;
  ouct_pkg::result_t res, out_q, hold_q;

  logic [CntW-1:0] count_q, count_d;
  logic            busy_q;
  logic            out_valid_q, hold_valid_q;
  logic            in_beat, exit_beat, out_take;

  assign s_axis_tready_o = !busy_q && !hold_valid_q;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;

  // Build the token for an accepted beat; it enters cell 0 at that edge.
  always_comb begin
    head.active     = in_beat;
    head.cmd        = s_axis_tuser_i;
    head.key.letter = s_axis_tdata_i[7:0];
    head.key.number = s_axis_tdata_i[15:8];
    head.key.symbol = s_axis_tdata_i[23:16];
    head.index      = s_axis_tdata_i[31:24];
    head.hit        = 1'b0;
    head.added      = 1'b0;
    head.data       = '0;
  end

  assign tok[0] = head;

  for (genvar i = 0; i < MaxEntries; i++) begin : g_cell
    ouct_pkg::entry_t next_entry;
    if (i < MaxEntries - 1) begin : g_mid
      assign next_entry = ent[i+1];
    end else begin : g_last
      // last slot has no successor; it drops out of range on removal anyway
      assign next_entry = ent[i];
    end
    ouct_cell #(
      .Idx  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .count_i      (count_q),
      .tok_i        (tok[i]),
      .tok_o        (tok[i+1]),
      .next_entry_i (next_entry),
      .entry_o      (ent[i])
    );
  end

  assign tail      = tok[MaxEntries];
  assign exit_beat = tail.active;
  assign out_take  = out_valid_q && m_axis_tready_i;

  // Turn the token leaving the chain into a result and the new count.
  always_comb begin
    count_d    = count_q;
    res.status = ouct_pkg::ST_OK;
    res.data   = tail.data;
    if (tail.active) begin
      unique case (tail.cmd)
        ouct_pkg::CMD_ADD: begin
          if (tail.hit) begin
            res.status = ouct_pkg::ST_MISS;
          end else if (tail.added) begin
            count_d = count_q + CntW'(1);
          end else begin
            res.status = ouct_pkg::ST_FULL;
          end
        end
        ouct_pkg::CMD_REMOVE: begin
          if (tail.hit) begin
            count_d = count_q - CntW'(1);
          end else begin
            res.status = ouct_pkg::ST_MISS;
          end
        end
        ouct_pkg::CMD_FIND: begin
          if (!tail.hit) begin
            res.status = ouct_pkg::ST_MISS;
          end
        end
        ouct_pkg::CMD_READ: begin
          if (!tail.hit) begin
            res.status = ouct_pkg::ST_RANGE;
          end
        end
        ouct_pkg::CMD_CLEAR: begin
          count_d = '0;
        end
        default: begin
        end
      endcase
    end
    res.count = 6'(count_d);
    res.empty = (count_d == '0);
  end

  // Control: count, busy flag and the two result slots.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      if (in_beat) begin
        busy_q <= 1'b1;
      end else if (exit_beat) begin
        busy_q <= 1'b0;
      end
      if (exit_beat) begin
        count_q <= count_d;
        // hold the result back if the output slot stays occupied
        if (out_valid_q && !out_take) begin
          hold_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        if (hold_valid_q) begin
          hold_valid_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  // Result payload: advance the holding slot when the output is taken.
  always_ff @(posedge clk_i) begin
    if (exit_beat) begin
      if (out_valid_q && !out_take) begin
        hold_q <= res;
      end else begin
        out_q <= res;
      end
    end else if (out_take && hold_valid_q) begin
      out_q <= hold_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_q.empty, out_q.count, out_q.data.symbol,
                            out_q.data.number, out_q.data.letter, out_q.status};

endmodule

// File: verif/tb.sv
// Self-checking bench for ordered_unique_coordinate_table_core: drives command beats,
// predicts every result beat with its own table model and compares field by field.
// Depends on ouct_pkg and the RTL of the table core.
module tb;

  // Command codes the block decodes as "do nothing"
  localparam logic [2:0] SPARE_CMD_LO = 3'd5;
  localparam logic [2:0] SPARE_CMD_HI = 3'd7;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned LONG_HOLD = 200;
  // Stimulus phases of the random part
  localparam int unsigned PH_GROW = 0;
  localparam int unsigned PH_MIXED = 1;
  localparam int unsigned PH_SHRINK = 2;

  // Mirror of the table: predicts one result per accepted command beat and
  // checks result beats against the oldest prediction.
  class table_tracker;
    ouct_pkg::entry_t  rows[ouct_pkg::MAX_ENTRIES];
    int unsigned       fill;
    ouct_pkg::result_t due_replies[$];
    int unsigned       errors;

    function int exact_at(ouct_pkg::entry_t key);
      for (int i = 0; i < fill; i++) begin
        if (rows[i] == key) return i;
      end
      return -1;
    endfunction

    function void note_command(logic [2:0] op, ouct_pkg::entry_t key, logic [7:0] pos);
      ouct_pkg::result_t r;
      int                at;
      r.status = ouct_pkg::ST_OK;
      r.data = '0;
      case (op)
        ouct_pkg::CMD_ADD: begin
          // duplicate test wins over the capacity test
          if (exact_at(key) >= 0) r.status = ouct_pkg::ST_MISS;
          else if (fill >= ouct_pkg::MAX_ENTRIES) r.status = ouct_pkg::ST_FULL;
          else begin
            rows[fill] = key;
            fill++;
          end
        end
        ouct_pkg::CMD_REMOVE: begin
          at = exact_at(key);
          if (at < 0) r.status = ouct_pkg::ST_MISS;
          else begin
            r.data = rows[at];
            // close the gap, keeping insertion order
            for (int i = at; i + 1 < fill; i++) rows[i] = rows[i + 1];
            fill--;
          end
        end
        ouct_pkg::CMD_FIND: begin
          r.status = ouct_pkg::ST_MISS;
          for (int i = 0; i < fill; i++) begin
            if (rows[i].letter == key.letter && rows[i].number == key.number) begin
              r.data = rows[i];
              r.status = ouct_pkg::ST_OK;
              break;
            end
          end
        end
        ouct_pkg::CMD_READ: begin
          if (pos < fill) r.data = rows[pos];
          else r.status = ouct_pkg::ST_RANGE;
        end
        ouct_pkg::CMD_CLEAR: fill = 0;
        default: ;
      endcase
      r.count = fill[5:0];
      r.empty = (fill == 0);
      due_replies.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
      if (got_v !== want_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(logic [39:0] beat);
      ouct_pkg::result_t want;
      if (due_replies.size() == 0) begin
        $error("result beat 0x%0h arrived with no command waiting for it", beat);
        errors++;
        return;
      end
      want = due_replies.pop_front();
      compare_field("status", 8'(want.status), 8'(beat[1:0]));
      compare_field("found_letter", want.data.letter, beat[9:2]);
      compare_field("found_number", want.data.number, beat[17:10]);
      compare_field("found_symbol", want.data.symbol, beat[25:18]);
      compare_field("entry_count", 8'(want.count), 8'(beat[31:26]));
      compare_field("table_empty", 8'(want.empty), 8'(beat[32]));
      compare_field("padding", 8'h00, 8'(beat[39:33]));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;
  logic [2:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;

  table_tracker tracker = new();
  bit calm;      // no idling on either side once set
  bit hold_req;  // ask the receiver for one long hold-off

  ordered_unique_coordinate_table_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Sample both channels at the rising edge; inputs only move on the falling
  // edge, so the values seen here are the ones the block registers.
  always @(posedge clk_i) begin
    ouct_pkg::entry_t key;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        key.letter = s_axis_tdata_i[7:0];
        key.number = s_axis_tdata_i[15:8];
        key.symbol = s_axis_tdata_i[23:16];
        tracker.note_command(s_axis_tuser_i, key, s_axis_tdata_i[31:24]);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) tracker.check_result(m_axis_tdata_o);
    end
  end

  // Receiver: short random stalls, one long hold-off on request, none when calm.
  always begin
    @(negedge clk_i);
    if (hold_req) begin
      m_axis_tready_i = 1'b0;
      repeat (LONG_HOLD) @(negedge clk_i);
      hold_req = 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      m_axis_tready_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
      m_axis_tready_i = 1'b1;
    end else begin
      m_axis_tready_i = 1'b1;
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  // Offer one command beat, with an optional idle burst in front; return at
  // the falling edge after the beat is taken, valid still high.
  task automatic send_beat(input logic [2:0] op, input ouct_pkg::entry_t key,
                           input logic [7:0] pos);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser_i  = op;
    s_axis_tdata_i  = {pos, key.symbol, key.number, key.letter};
    s_axis_tvalid_i = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Draw one random command, weighted by phase. Keys are often taken from the
  // live table so that duplicates, hits and removals are frequent.
  task automatic pick_item(input int unsigned phase, output logic [2:0] op,
                           output ouct_pkg::entry_t key, output logic [7:0] pos);
    int unsigned roll;
    int unsigned src;
    int unsigned add_top;
    int unsigned rem_top;
    int unsigned find_top;
    int unsigned read_top;
    int unsigned clear_top;
    case (phase)
      PH_GROW: begin
        add_top = 70; rem_top = 78; find_top = 87; read_top = 96; clear_top = 96;
      end
      PH_MIXED: begin
        add_top = 35; rem_top = 60; find_top = 77; read_top = 93; clear_top = 96;
      end
      default: begin
        add_top = 15; rem_top = 65; find_top = 79; read_top = 93; clear_top = 96;
      end
    endcase
    roll = $urandom_range(0, 99);
    src = $urandom_range(0, 99);
    key.letter = 8'($urandom_range(0, 255));
    key.number = 8'($urandom_range(0, 255));
    key.symbol = 8'($urandom_range(0, 255));
    pos = 8'($urandom_range(0, 255));
    if (roll < add_top) op = ouct_pkg::CMD_ADD;
    else if (roll < rem_top) op = ouct_pkg::CMD_REMOVE;
    else if (roll < find_top) op = ouct_pkg::CMD_FIND;
    else if (roll < read_top) op = ouct_pkg::CMD_READ;
    else if (roll < clear_top) op = ouct_pkg::CMD_CLEAR;
    else op = 3'($urandom_range(SPARE_CMD_LO, SPARE_CMD_HI));
    if (tracker.fill > 0) begin
      // take a stored entry: exact copy, or same position with a new symbol
      if ((op == ouct_pkg::CMD_ADD && src < 25) ||
          ((op == ouct_pkg::CMD_REMOVE || op == ouct_pkg::CMD_FIND) && src < 70)) begin
        key = tracker.rows[$urandom_range(0, tracker.fill - 1)];
        if (src < 12) key.symbol = 8'($urandom_range(0, 255));
      end
      if (op == ouct_pkg::CMD_READ && src < 80) begin
        pos = 8'($urandom_range(0, tracker.fill - 1));
      end
    end
  endtask

  initial begin
    logic [2:0]       op;
    ouct_pkg::entry_t key;
    logic [7:0]       pos;
    int unsigned      counted;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = ouct_pkg::CMD_CLEAR;
    m_axis_tready_i = 1'b0;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: every command on an empty table, field extremes, duplicates,
    // same position with another symbol, compaction after a middle removal,
    // reads past the count and the unused command codes.
    send_beat(ouct_pkg::CMD_CLEAR,  '{8'd0, 8'd0, 8'd0}, 8'd0);
    send_beat(ouct_pkg::CMD_FIND,   '{8'd0, 8'd0, 8'd0}, 8'd0);
    send_beat(ouct_pkg::CMD_READ,   '{8'd0, 8'd0, 8'd0}, 8'd0);
    send_beat(ouct_pkg::CMD_REMOVE, '{8'd0, 8'd0, 8'd0}, 8'd0);
    send_beat(ouct_pkg::CMD_ADD,    '{8'd0, 8'd0, 8'd0}, 8'd0);
    send_beat(ouct_pkg::CMD_ADD,    '{8'd255, 8'd255, 8'd255}, 8'd255);
    send_beat(ouct_pkg::CMD_ADD,    '{8'd0, 8'd0, 8'd0}, 8'd0);
    send_beat(ouct_pkg::CMD_ADD,    '{8'd0, 8'd0, 8'd255}, 8'd0);
    send_beat(ouct_pkg::CMD_FIND,   '{8'd0, 8'd0, 8'd77}, 8'd0);
    send_beat(ouct_pkg::CMD_FIND,   '{8'd255, 8'd255, 8'd0}, 8'd0);
    send_beat(ouct_pkg::CMD_FIND,   '{8'd1, 8'd0, 8'd0}, 8'd0);
    send_beat(ouct_pkg::CMD_READ,   '{8'd0, 8'd0, 8'd0}, 8'd2);
    send_beat(ouct_pkg::CMD_READ,   '{8'd0, 8'd0, 8'd0}, 8'd3);
    send_beat(ouct_pkg::CMD_READ,   '{8'd0, 8'd0, 8'd0}, 8'd255);
    send_beat(ouct_pkg::CMD_REMOVE, '{8'd255, 8'd255, 8'd255}, 8'd0);
    send_beat(ouct_pkg::CMD_READ,   '{8'd0, 8'd0, 8'd0}, 8'd1);
    send_beat(ouct_pkg::CMD_REMOVE, '{8'd0, 8'd0, 8'd7}, 8'd0);
    send_beat(SPARE_CMD_LO,         '{8'd255, 8'd255, 8'd255}, 8'd255);
    send_beat(SPARE_CMD_HI,         '{8'd0, 8'd0, 8'd0}, 8'd0);
    send_beat(ouct_pkg::CMD_CLEAR,  '{8'd255, 8'd255, 8'd255}, 8'd255);
    send_beat(ouct_pkg::CMD_READ,   '{8'd0, 8'd0, 8'd0}, 8'd0);

    // Random: phases of 60 counted items in the order grow, mixed, grow,
    // shrink, so the table fills to capacity and drains again repeatedly.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      case ((counted / 60) % 4)
        0, 2:    pick_item(PH_GROW, op, key, pos);
        1:       pick_item(PH_MIXED, op, key, pos);
        default: pick_item(PH_SHRINK, op, key, pos);
      endcase
      send_beat(op, key, pos);
      // unused codes leave the table unchanged: do not count them
      if (op < SPARE_CMD_LO) begin
        counted++;
        if (counted == 200) hold_req = 1'b1;
        if (counted == 400) begin
          // pause the sender until every result is back
          s_axis_tvalid_i = 1'b0;
          while (tracker.due_replies.size() != 0) @(posedge clk_i);
          @(negedge clk_i);
        end
        if (counted == RANDOM_ITEMS - 100) calm = 1'b1;
      end
    end
    s_axis_tvalid_i = 1'b0;

    // Drain, then give the chain one more pass to show any stray result.
    while (tracker.due_replies.size() != 0) @(posedge clk_i);
    repeat (ouct_pkg::MAX_ENTRIES + 8) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.due_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
